### rtl/itda_pkg.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII package
// Shared constants and the command and status types that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package itda_pkg;

    localparam int DataWidth  = 32;
    localparam int NumDigits  = 10;
    localparam int DigitW     = 4;
    localparam int IdxW       = $clog2(NumDigits);
    localparam int BitCntW    = $clog2(DataWidth);
    localparam int CharW      = 8;
    localparam int CountW     = 4;

    localparam logic [CharW-1:0] CharZero  = 8'h30;
    localparam logic [CharW-1:0] CharMinus = 8'h2D;

    // Input mode codes.
    localparam logic OpSigned   = 1'b0;
    localparam logic OpUnsigned = 1'b1;

    typedef logic [DigitW-1:0] t_digit;

    typedef struct packed {
        logic load;
        logic shift;
        logic step_down;
        logic seal;
        logic emit_sign;
        logic emit_digit;
    } t_itda_cmd;

    typedef struct packed {
        logic neg;
        logic idx_zero;
        logic digit_zero;
        logic out_free;
    } t_itda_sts;

endpackage

### rtl/itda_if.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII channel interfaces
// Valid/ready channels for the input numbers and the output characters.
// ----------------------------------------------------------------------------
interface itda_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface itda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    logic [3:0] char_count;

    modport source (output valid, output character, output last, output char_count,
                    input ready);
    modport sink   (input valid, input character, input last, input char_count,
                    output ready);
endinterface

### rtl/integer_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII unit
// Converts a 32-bit signed or unsigned word to its decimal text as a stream
// of ASCII characters, most significant digit first.
// ----------------------------------------------------------------------------
// One number is handled at a time. The cycle an input transaction is taken,
// the word is loaded (negated first when it is a negative signed value), and
// a shift-and-add-3 converter then turns it into ten BCD digits, one input
// bit per cycle. Next the digit pointer walks down past the leading zeros,
// never past the ones digit, and then one character leaves per cycle while
// the output register is free: an optional '-' followed by the significant
// digits. The output sits in a register, so the next input transaction is
// accepted while the final character of the previous number still waits
// for the consumer. The final character carries last and the total number
// of characters of the number (1 to 11); on all other characters the count
// is zero.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_unit
    import itda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    itda_in_if.sink     i_in,
    itda_out_if.source  o_out
);

    t_itda_cmd cmd;
    t_itda_sts sts;

    // The controller only sequences; all number handling lives in the datapath.
    itda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    itda_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_in.op),
        .i_value      (i_in.value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_character  (o_out.character),
        .o_last       (o_out.last),
        .o_char_count (o_out.char_count)
    );

    // A character is never loaded while the unit is free to take a new number.
    a_no_emit_when_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> !i_in.ready
    ) else $error("character emitted while accepting input");

    // Accepting a number starts the conversion, so the next cycle is busy.
    a_busy_after_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (!i_in.ready && cmd.shift)
    ) else $error("conversion did not start after input transaction");

    // The count is present only on the final character and lies in range.
    a_count_rule: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last ? (o_out.char_count != 4'd0 &&
                                       o_out.char_count <= 4'd11)
                                    : (o_out.char_count == 4'd0))
    ) else $error("bad character count");

    // Only a minus sign or a decimal digit is ever emitted.
    a_char_legal: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.character == CharMinus ||
                         (o_out.character >= CharZero &&
                          o_out.character <= CharZero + 8'd9))
    ) else $error("illegal character emitted");

endmodule

### rtl/itda_ctrl.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII controller
// Sequences conversion, leading-zero skip and character emission.
// ----------------------------------------------------------------------------
module itda_ctrl
    import itda_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_itda_sts i_sts,
    output t_itda_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    localparam logic [BitCntW-1:0] LastBit = BitCntW'(DataWidth - 1);

    t_state             r_state, n_state;
    logic [BitCntW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.shift = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == LastBit) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Walk down past leading zeros, always keeping the ones digit.
                if (!i_sts.idx_zero && i_sts.digit_zero) begin
                    o_cmd.step_down = 1'b1;
                end else begin
                    o_cmd.seal = 1'b1;
                    n_state    = i_sts.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.idx_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### rtl/itda_dp.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII datapath
// Shift-and-add-3 binary to BCD converter, digit pointer and output register.
// ----------------------------------------------------------------------------
module itda_dp
    import itda_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_op,
    input  logic [DataWidth-1:0] i_value,
    input  t_itda_cmd            i_cmd,
    output t_itda_sts            o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [CharW-1:0]     o_character,
    output logic                 o_last,
    output logic [CountW-1:0]    o_char_count
);

    logic [DataWidth-1:0] r_mag;
    t_digit               r_bcd [NumDigits];
    t_digit               adj   [NumDigits];
    logic                 r_neg;
    logic [IdxW-1:0]      r_idx;
    logic [CountW-1:0]    r_total;
    logic                 r_out_valid;
    logic [CharW-1:0]     r_char;
    logic                 r_last;
    logic [CountW-1:0]    r_count;
    logic                 load_neg;
    t_digit               cur_digit;

    assign load_neg  = (i_op == OpSigned) && i_value[DataWidth-1];
    assign cur_digit = r_bcd[r_idx];

    // Digits of five or more are corrected before each doubling.
    always_comb begin
        for (int i = 0; i < NumDigits; i++) begin
            adj[i] = (r_bcd[i] >= DigitW'(5)) ? r_bcd[i] + DigitW'(3) : r_bcd[i];
        end
    end

    assign o_sts.neg        = r_neg;
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.digit_zero = (cur_digit == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= load_neg;
            r_mag <= load_neg ? (~i_value + 1'b1) : i_value;
            r_idx <= IdxW'(NumDigits - 1);
            for (int i = 0; i < NumDigits; i++) begin
                r_bcd[i] <= '0;
            end
        end else if (i_cmd.shift) begin
            r_mag    <= {r_mag[DataWidth-2:0], 1'b0};
            r_bcd[0] <= {adj[0][DigitW-2:0], r_mag[DataWidth-1]};
            for (int i = 1; i < NumDigits; i++) begin
                r_bcd[i] <= {adj[i][DigitW-2:0], adj[i-1][DigitW-1]};
            end
        end else if (i_cmd.step_down || (i_cmd.emit_digit && (r_idx != '0))) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.seal) begin
            r_total <= CountW'(r_idx) + CountW'(1) + CountW'(r_neg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char  <= CharMinus;
            r_last  <= 1'b0;
            r_count <= '0;
        end else if (i_cmd.emit_digit) begin
            r_char  <= CharZero + CharW'(cur_digit);
            r_last  <= (r_idx == '0);
            r_count <= (r_idx == '0) ? r_total : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_character  = r_char;
    assign o_last       = r_last;
    assign o_char_count = r_count;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to decimal ASCII unit testbench
// Sends 32-bit words in signed and unsigned mode and checks every ASCII
// character that comes back, with its last flag and count. The expected text
// is typed in for the easy directed cases and computed in the testbench for
// all others. Both channels idle at random, in several mixes.
// ----------------------------------------------------------------------------
module tb_top
    import itda_pkg::*;
();

    // Room for the longest text: a minus sign and ten digits.
    localparam int TextChars     = NumDigits + 1;
    localparam int TextW         = TextChars * CharW;
    localparam int NumRows       = 22;
    localparam int ItemsPerPhase = 100;
    // Cycles with no transaction on either channel before the run is stopped,
    // set far beyond the gaps that conversion and a stalling consumer cause.
    localparam int WatchdogLimit = 2000;
    // Cycles to wait after the last expected character.
    localparam int DrainCycles   = 60;

    // One row of the directed table. A text of all zero bytes means the
    // expected characters come from the predictor instead.
    typedef struct packed {
        logic                 op;
        logic [DataWidth-1:0] value;
        logic [TextW-1:0]     text;
    } t_number_row;

    // One expected output character.
    typedef struct packed {
        logic [CharW-1:0]  character;
        logic              last;
        logic [CountW-1:0] count;
    } t_char_exp;

    logic clk;
    logic rst_n;

    itda_in_if  in_if ();
    itda_out_if out_if ();

    integer_to_decimal_ascii_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Characters still owed by the block, oldest first.
    t_char_exp pending_chars [$];
    t_char_exp next_char;

    int src_idle_pct;
    int snk_idle_pct;
    int error_count;
    int idle_cycles;
    int numbers_sent;
    int negatives_sent;
    int unsigned_sent;
    int chars_checked;
    int shortest_text;
    int longest_text;

    // Text strings are right-justified into the packed text field, so the
    // first character of the number sits in the highest non-zero byte.
    t_number_row directed_rows [NumRows] = '{
        '{op: OpUnsigned, value: 32'h0000_0000,   text: "0"},
        '{op: OpSigned,   value: 32'h0000_0000,   text: "0"},
        '{op: OpSigned,   value: 32'h0000_0001,   text: "1"},
        '{op: OpSigned,   value: 32'h8000_0000,   text: "-2147483648"},
        '{op: OpUnsigned, value: 32'h8000_0000,   text: "2147483648"},
        '{op: OpSigned,   value: 32'h7FFF_FFFF,   text: "2147483647"},
        '{op: OpUnsigned, value: 32'h7FFF_FFFF,   text: "2147483647"},
        '{op: OpSigned,   value: 32'hFFFF_FFFF,   text: "-1"},
        '{op: OpUnsigned, value: 32'hFFFF_FFFF,   text: "4294967295"},
        '{op: OpSigned,   value: 32'd9,           text: "9"},
        '{op: OpUnsigned, value: 32'd10,          text: "10"},
        '{op: OpSigned,   value: 32'hFFFF_FFF6,   text: "-10"},
        '{op: OpUnsigned, value: 32'hFFFF_FFF6,   text: "4294967286"},
        '{op: OpUnsigned, value: 32'd999999999,   text: "999999999"},
        '{op: OpUnsigned, value: 32'd1000000000,  text: "1000000000"},
        '{op: OpSigned,   value: 32'd1000000000,  text: "1000000000"},
        '{op: OpSigned,   value: 32'hC465_3600,   text: "-1000000000"},
        '{op: OpUnsigned, value: 32'd4000000000,  text: "4000000000"},
        '{op: OpSigned,   value: 32'hDEAD_BEEF,   text: '0},
        '{op: OpUnsigned, value: 32'hDEAD_BEEF,   text: '0},
        '{op: OpSigned,   value: 32'h5555_5555,   text: '0},
        '{op: OpUnsigned, value: 32'hAAAA_AAAA,   text: '0}
    };

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Decimal text of one word, right-justified, computed digit by digit
    // from the least significant end. A negative signed word is negated as
    // an unsigned 32-bit number, which keeps the most negative value right.
    function automatic logic [TextW-1:0] decimal_text(input logic op,
                                                      input logic [DataWidth-1:0] value);
        logic [TextW-1:0]     text;
        logic [DataWidth-1:0] mag;
        logic                 negative;
        int                   pos;
        negative = (op == OpSigned) && value[DataWidth-1];
        mag      = negative ? -value : value;
        text     = '0;
        pos      = 0;
        do begin
            text[CharW*pos +: CharW] = CharZero + CharW'(mag % 10);
            mag = mag / 10;
            pos++;
        end while (mag != 0);
        if (negative) begin
            text[CharW*pos +: CharW] = CharMinus;
        end
        return text;
    endfunction

    // Turns a text into expected characters. Only the final one carries the
    // last flag and the length; all earlier ones carry a count of zero.
    function automatic void queue_text(input logic [TextW-1:0] text);
        t_char_exp c;
        int        len;
        len = 0;
        for (int i = 0; i < TextChars; i++) begin
            if (text[CharW*i +: CharW] != '0) begin
                len = i + 1;
            end
        end
        for (int i = len - 1; i >= 0; i--) begin
            c.character = text[CharW*i +: CharW];
            c.last      = (i == 0);
            c.count     = (i == 0) ? CountW'(len) : '0;
            pending_chars.push_back(c);
        end
        if (len < shortest_text) shortest_text = len;
        if (len > longest_text) longest_text = len;
    endfunction

    // Offers one number, with a random gap in front of it. Valid stays high
    // on return so that a following number without a gap goes back to back.
    task automatic send_number(input logic op, input logic [DataWidth-1:0] value,
                               input logic [TextW-1:0] text);
        if ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            in_if.op    <= 1'($urandom_range(1));
            in_if.value <= $urandom;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_if.valid <= 1'b1;
        in_if.op    <= op;
        in_if.value <= value;
        do @(posedge clk); while (!in_if.ready);
        queue_text(text);
        numbers_sent++;
        if (op == OpUnsigned) unsigned_sent++;
        else if (value[DataWidth-1]) negatives_sent++;
    endtask

    // Stops offering input until every owed character has come out.
    task automatic hold_until_drained();
        in_if.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
    endtask

    // Random words spread over all text lengths: full-range words, small
    // numbers, values around powers of ten, small negatives, and words with a
    // random number of leading zero bits.
    function automatic logic [DataWidth-1:0] random_word();
        logic [DataWidth-1:0] p;
        int                   k;
        p = 1;
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(0, 99999);
            2: begin
                k = $urandom_range(9);
                repeat (k) p = p * 10;
                return p + $urandom_range(2) - 1;
            end
            3: return 32'(0) - $urandom_range(1, 100000);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    // Consumer side: random ready, and every accepted character is checked
    // against the oldest expectation.
    always @(posedge clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        if (rst_n && out_if.valid && out_if.ready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h",
                                          out_if.character));
            end else begin
                next_char = pending_chars.pop_front();
                if (out_if.character !== next_char.character)
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              out_if.character, next_char.character));
                if (out_if.last !== next_char.last)
                    report_mismatch($sformatf("last %b, expected %b on character 0x%02h",
                                              out_if.last, next_char.last,
                                              next_char.character));
                if (out_if.char_count !== next_char.count)
                    report_mismatch($sformatf("char_count %0d, expected %0d",
                                              out_if.char_count, next_char.count));
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("Watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic op;
        logic [DataWidth-1:0] value;

        error_count    = 0;
        numbers_sent   = 0;
        negatives_sent = 0;
        unsigned_sent  = 0;
        shortest_text  = TextChars;
        longest_text   = 0;
        src_idle_pct   = 36;
        snk_idle_pct   = 83;

        in_if.valid  <= 1'b0;
        in_if.op     <= OpSigned;
        in_if.value  <= '0;
        rst_n        <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: typed text where it is obvious, else predicted.
        for (int r = 0; r < NumRows; r++) begin
            send_number(directed_rows[r].op, directed_rows[r].value,
                        (directed_rows[r].text != '0) ? directed_rows[r].text
                        : decimal_text(directed_rows[r].op, directed_rows[r].value));
        end
        hold_until_drained();

        // Random phases: slow consumer, then slow producer, then full speed.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 36; snk_idle_pct = 83; end
                1: begin src_idle_pct = 83; snk_idle_pct = 36; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int n = 0; n < ItemsPerPhase; n++) begin
                op    = $urandom_range(1) ? OpUnsigned : OpSigned;
                value = random_word();
                send_number(op, value, decimal_text(op, value));
                // Now and then let the block run completely dry.
                if ($urandom_range(49) == 0) hold_until_drained();
            end
            hold_until_drained();
        end

        repeat (DrainCycles) @(posedge clk);
        if (pending_chars.size() != 0) begin
            report_mismatch($sformatf("%0d expected characters never arrived",
                                      pending_chars.size()));
        end

        $display("Converted %0d numbers (%0d negative signed, %0d unsigned), %0d characters",
                 numbers_sent, negatives_sent, unsigned_sent, chars_checked);
        $display("Text lengths %0d to %0d, under three idle mixes on both channels",
                 shortest_text, longest_text);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
rtl/itda_pkg.sv
rtl/itda_if.sv
rtl/itda_ctrl.sv
rtl/itda_dp.sv
rtl/integer_to_decimal_ascii_unit.sv
tb/sv/tb_top.sv
